// File: src/psf_pkg.sv
// shared types, constants and arithmetic helpers for the steering force pipeline
`default_nettype none

package psf_pkg;

	// fixed point position of the binary point
	localparam int FRAC_BITS = 16;

	// one result bit per stage in the length and divide units
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 64;

	// unity in the fixed point format, used to scale distance into speed
	localparam logic [31:0] FRAC_ONE = 32'd1 << FRAC_BITS;

	// register reset values (0.3 and 0.6 in Q.F)
	localparam logic [30:0] FAST_DIV_RESET = 31'd19661;
	localparam logic [30:0] NORM_DIV_RESET = 31'd39322;

	typedef logic signed [31:0] s32_t;
	typedef logic [31:0]        u32_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_ENABLE    = 3'd0,
		CFG_MAX_FORCE = 3'd1,
		CFG_MAX_SPEED = 3'd2,
		CFG_IP_DIST   = 3'd3,
		CFG_FAST_DIV  = 3'd4,
		CFG_NORM_DIV  = 3'd5
	} cfg_idx_t;

	// behaviour enable bits
	localparam int EN_SEEK   = 0;
	localparam int EN_ARRIVE = 1;
	localparam int EN_IPOSE  = 2;

	typedef struct packed {
		logic [2:0]  behav_en;
		logic [30:0] max_force;
		logic [30:0] max_speed;
		s32_t        ip_dist;
		logic [30:0] fast_div;
		logic [30:0] norm_div;
	} cfg_t;

	// everything a word carries down the pipeline
	typedef struct packed {
		s32_t        tx;
		s32_t        ty;
		s32_t        px;
		s32_t        py;
		s32_t        vx;
		s32_t        vy;
		s32_t        dx;
		s32_t        dy;
		u32_t        len_d;
		s32_t        seek_x;
		s32_t        seek_y;
		s32_t        off_x;
		s32_t        off_y;
		logic [30:0] spd1;
		logic [30:0] spd2;
		s32_t        to2_x;
		s32_t        to2_y;
		u32_t        dist2;
		s32_t        arr_x;
		s32_t        arr_y;
		s32_t        ip_x;
		s32_t        ip_y;
		s32_t        run_x;
		s32_t        run_y;
		s32_t        tot_x;
		s32_t        tot_y;
		u32_t        lr;
		logic        go;
		logic        act;
	} ctx_t;

	// clamp a 33 bit signed value to the 32 bit range
	function automatic s32_t sat33(input logic signed [32:0] s);
		s32_t r;
		if (s[32] != s[31]) begin
			r = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	function automatic s32_t sadd(input s32_t a, input s32_t b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		return sat33(s);
	endfunction

	function automatic s32_t ssub(input s32_t a, input s32_t b);
		logic signed [32:0] s;
		s = {a[31], a} - {b[31], b};
		return sat33(s);
	endfunction

	// magnitude, the most negative value maps to 2^31
	function automatic u32_t mag(input s32_t v);
		u32_t r;
		r = v[31] ? (~u32_t'(v) + 32'd1) : u32_t'(v);
		return r;
	endfunction

	// signed, saturated component from an unsigned quotient
	function automatic s32_t fix_scale(input logic [63:0] q, input logic neg, input logic zero);
		s32_t r;
		if (zero) begin
			r = '0;
		end else if (neg) begin
			r = (q > 64'd2147483648) ? 32'sh8000_0000 : s32_t'(~q[31:0] + 32'd1);
		end else begin
			r = (q > 64'd2147483647) ? 32'sh7fff_ffff : s32_t'(q[31:0]);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: src/psf_len.sv
// vector length unit: squares, sum and a one bit per stage integer square root
`default_nettype none

module psf_len
	import psf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld,
	input  ctx_t ctx,
	input  s32_t vec_x,
	input  s32_t vec_y,
	output logic len_valid,
	output ctx_t len_ctx,
	output u32_t len
);

	logic        v_s1, v_s2, v_s3;
	ctx_t        ctx_s1, ctx_s2, ctx_s3;
	u32_t        ax_s1, ay_s1;
	logic [63:0] sx_s2, sy_s2;
	logic [63:0] sum_s3;

	logic        vld_s  [1:SQRT_STEPS];
	ctx_t        ctx_s  [1:SQRT_STEPS];
	logic [63:0] num_s  [1:SQRT_STEPS];
	logic [33:0] rem_s  [1:SQRT_STEPS];
	u32_t        root_s [1:SQRT_STEPS];

	// front valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// magnitudes, squares, sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx;
			ax_s1  <= mag(vec_x);
			ay_s1  <= mag(vec_y);
			ctx_s2 <= ctx_s1;
			sx_s2  <= 64'(ax_s1) * 64'(ax_s1);
			sy_s2  <= 64'(ay_s1) * 64'(ay_s1);
			ctx_s3 <= ctx_s2;
			sum_s3 <= sx_s2 + sy_s2;
		end
	end

	// square root, two radicand bits consumed per stage
	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
		logic        cur_v;
		ctx_t        cur_ctx;
		logic [63:0] cur_num;
		logic [33:0] cur_rem;
		u32_t        cur_root;
		logic [35:0] rem_sh;
		logic [35:0] trial;
		logic        fit;

		if (i == 0) begin : g_first
			assign cur_v    = v_s3;
			assign cur_ctx  = ctx_s3;
			assign cur_num  = sum_s3;
			assign cur_rem  = '0;
			assign cur_root = '0;
		end else begin : g_next
			assign cur_v    = vld_s[i];
			assign cur_ctx  = ctx_s[i];
			assign cur_num  = num_s[i];
			assign cur_rem  = rem_s[i];
			assign cur_root = root_s[i];
		end

		assign rem_sh = {cur_rem, cur_num[63:62]};
		assign trial  = {2'b00, cur_root, 2'b01};
		assign fit    = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[i+1] <= cur_ctx;
				num_s[i+1] <= {cur_num[61:0], 2'b00};
				if (fit) begin
					rem_s[i+1]  <= 34'(rem_sh - trial);
					root_s[i+1] <= {cur_root[30:0], 1'b1};
				end else begin
					rem_s[i+1]  <= rem_sh[33:0];
					root_s[i+1] <= {cur_root[30:0], 1'b0};
				end
			end
		end
	end

	assign len_valid = vld_s[SQRT_STEPS];
	assign len_ctx   = ctx_s[SQRT_STEPS];
	assign len       = root_s[SQRT_STEPS];

endmodule

`default_nettype wire

// File: src/psf_scale.sv
// two lane multiply then divide unit: q = a * b / den, one quotient bit per stage
`default_nettype none

module psf_scale
	import psf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld,
	input  ctx_t        ctx,
	input  logic [32:0] a_x,
	input  logic [32:0] a_y,
	input  u32_t        b_x,
	input  u32_t        b_y,
	input  u32_t        den_x,
	input  u32_t        den_y,
	output logic        q_valid,
	output ctx_t        q_ctx,
	output logic [63:0] q_x,
	output logic [63:0] q_y
);

	logic        v_s1, v_s2;
	ctx_t        ctx_s1, ctx_s2;
	logic [32:0] ax_s1, ay_s1;
	u32_t        bx_s1, by_s1, dx_s1, dy_s1;
	logic [63:0] px_s2, py_s2;
	u32_t        dx_s2, dy_s2;

	logic        vld_s [1:DIV_STEPS];
	ctx_t        ctx_s [1:DIV_STEPS];
	logic [63:0] nqx_s [1:DIV_STEPS];
	logic [63:0] nqy_s [1:DIV_STEPS];
	u32_t        rx_s  [1:DIV_STEPS];
	u32_t        ry_s  [1:DIV_STEPS];
	u32_t        dvx_s [1:DIV_STEPS];
	u32_t        dvy_s [1:DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld;
			v_s2 <= v_s1;
		end
	end

	// operand capture, then products
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx;
			ax_s1  <= a_x;
			ay_s1  <= a_y;
			bx_s1  <= b_x;
			by_s1  <= b_y;
			dx_s1  <= den_x;
			dy_s1  <= den_y;
			ctx_s2 <= ctx_s1;
			px_s2  <= 64'(ax_s1) * 64'(bx_s1);
			py_s2  <= 64'(ay_s1) * 64'(by_s1);
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
		end
	end

	// restoring division, quotient bits shift in as numerator bits shift out
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic        cur_v;
		ctx_t        cur_ctx;
		logic [63:0] cur_nx, cur_ny;
		u32_t        cur_rx, cur_ry, cur_dx, cur_dy;
		logic [32:0] shx, shy;
		logic        fx, fy;

		if (i == 0) begin : g_first
			assign cur_v   = v_s2;
			assign cur_ctx = ctx_s2;
			assign cur_nx  = px_s2;
			assign cur_ny  = py_s2;
			assign cur_rx  = '0;
			assign cur_ry  = '0;
			assign cur_dx  = dx_s2;
			assign cur_dy  = dy_s2;
		end else begin : g_next
			assign cur_v   = vld_s[i];
			assign cur_ctx = ctx_s[i];
			assign cur_nx  = nqx_s[i];
			assign cur_ny  = nqy_s[i];
			assign cur_rx  = rx_s[i];
			assign cur_ry  = ry_s[i];
			assign cur_dx  = dvx_s[i];
			assign cur_dy  = dvy_s[i];
		end

		assign shx = {cur_rx, cur_nx[63]};
		assign shy = {cur_ry, cur_ny[63]};
		assign fx  = shx >= {1'b0, cur_dx};
		assign fy  = shy >= {1'b0, cur_dy};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[i+1] <= cur_ctx;
				dvx_s[i+1] <= cur_dx;
				dvy_s[i+1] <= cur_dy;
				nqx_s[i+1] <= {cur_nx[62:0], fx};
				nqy_s[i+1] <= {cur_ny[62:0], fy};
				rx_s[i+1]  <= fx ? 32'(shx - {1'b0, cur_dx}) : shx[31:0];
				ry_s[i+1]  <= fy ? 32'(shy - {1'b0, cur_dy}) : shy[31:0];
			end
		end
	end

	assign q_valid = vld_s[DIV_STEPS];
	assign q_ctx   = ctx_s[DIV_STEPS];
	assign q_x     = nqx_s[DIV_STEPS];
	assign q_y     = nqy_s[DIV_STEPS];

endmodule

`default_nettype wire

// File: src/psf_budget.sv
// one budget step: add a behaviour into the running force, clip into what is left
`default_nettype none

module psf_budget
	import psf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld,
	input  ctx_t        ctx,
	input  s32_t        force_x,
	input  s32_t        force_y,
	input  logic        act,
	input  logic [30:0] max_force,
	output logic        step_valid,
	output ctx_t        step_ctx
);

	logic               v_s1, v_s2, v_s3;
	ctx_t               ctx_s1, ctx_s2, ctx_s3;
	ctx_t               nxt1, nxt2, nxt3;
	logic [30:0]        add_s2;
	logic [30:0]        add_c;
	logic               lt_valid;
	ctx_t               lt_ctx;
	u32_t               len_tot, len_run;
	logic signed [33:0] left;
	logic               q_valid;
	ctx_t               q_ctx;
	logic [63:0]        q_x, q_y;

	// running force picks up this behaviour when it is enabled and budget remains
	always_comb begin
		nxt1     = ctx;
		nxt1.act = act & ctx.go;
		if (nxt1.act) begin
			nxt1.run_x = sadd(ctx.run_x, force_x);
			nxt1.run_y = sadd(ctx.run_y, force_y);
		end
	end

	psf_len u_len_tot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld       (v_s1),
		.ctx       (ctx_s1),
		.vec_x     (ctx_s1.tot_x),
		.vec_y     (ctx_s1.tot_y),
		.len_valid (lt_valid),
		.len_ctx   (lt_ctx),
		.len       (len_tot)
	);

	psf_len u_len_run (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.vld       (v_s1),
		.ctx       (ctx_s1),
		.vec_x     (ctx_s1.run_x),
		.vec_y     (ctx_s1.run_y),
		.len_valid (),
		.len_ctx   (),
		.len       (len_run)
	);

	// budget left, stop the chain when it is used up
	always_comb begin
		left    = $signed({3'b000, max_force}) - $signed({2'b00, len_tot});
		nxt2    = lt_ctx;
		nxt2.lr = len_run;
		if (lt_ctx.act && left <= 34'sd0) begin
			nxt2.act = 1'b0;
			nxt2.go  = 1'b0;
		end
		add_c = ($signed({2'b00, len_run}) > left) ? left[30:0] : len_run[30:0];
	end

	psf_scale u_clip (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (v_s2),
		.ctx     (ctx_s2),
		.a_x     ({1'b0, mag(ctx_s2.run_x)}),
		.a_y     ({1'b0, mag(ctx_s2.run_y)}),
		.b_x     ({1'b0, add_s2}),
		.b_y     ({1'b0, add_s2}),
		.den_x   (ctx_s2.lr),
		.den_y   (ctx_s2.lr),
		.q_valid (q_valid),
		.q_ctx   (q_ctx),
		.q_x     (q_x),
		.q_y     (q_y)
	);

	// clipped running force goes into the total
	always_comb begin
		nxt3 = q_ctx;
		if (q_ctx.act) begin
			nxt3.tot_x = sadd(q_ctx.tot_x, fix_scale(q_x, q_ctx.run_x[31], q_ctx.lr == '0));
			nxt3.tot_y = sadd(q_ctx.tot_y, fix_scale(q_y, q_ctx.run_y[31], q_ctx.lr == '0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld;
			v_s2 <= lt_valid;
			v_s3 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= nxt1;
			ctx_s2 <= nxt2;
			add_s2 <= add_c;
			ctx_s3 <= nxt3;
		end
	end

	assign step_valid = v_s3;
	assign step_ctx   = ctx_s3;

endmodule

`default_nettype wire

// File: src/prioritized_steering_force_top.sv
// top level of the prioritised seek / arrive / interpose steering force pipeline
//
//   channel | handshake                   | payload
//   --------+-----------------------------+----------------------------------------
//   in      | in_valid / in_stall         | target_x/y, pos_x/y, vel_x/y
//   out     | out_valid / out_stall       | force_x, force_y
//   cfg     | cfg_wen, cfg_idx, cfg_wdata | six registers, written without wait
//
// one word enters per cycle unless the pipeline is stalled; from acceptance each word passes
// a chain of length units (32 root stages) and divide units (64 quotient stages).
// a stalled result freezes the whole pipeline, so nothing is dropped or repeated.
// asynchronous reset clears valid bits and sets configuration to its reset values; no clearing pass is needed.
`default_nettype none

module prioritized_steering_force_top
	import psf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  s32_t        target_x,
	input  s32_t        target_y,
	input  s32_t        pos_x,
	input  s32_t        pos_y,
	input  s32_t        vel_x,
	input  s32_t        vel_y,
	output logic        out_valid,
	input  logic        out_stall,
	output s32_t        force_x,
	output s32_t        force_y,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);

	cfg_t cfg_q;
	logic en;

	logic v_s0, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	ctx_t c_s0, c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7, c_s8;
	ctx_t n_s0, n_s1, n_s2, n_s3, n_s4, n_s5, n_s6, n_s7, n_s8;
	s32_t fx_s9, fy_s9;
	s32_t fx_c, fy_c;

	logic        l1_v, l2_v, lf_v;
	ctx_t        l1_ctx, l2_ctx, lf_ctx;
	u32_t        l1_len, l2_len, lf_len;
	logic        sk_v, a1_v, a2_v, sf_v;
	ctx_t        sk_ctx, a1_ctx, a2_ctx, sf_ctx;
	logic [63:0] sk_x, sk_y, of_x, of_y, sp1_q, sp2_q, a1_x, a1_y, a2_x, a2_y, sf_x, sf_y;
	logic [63:0] sp1_unused, sp2_unused;
	logic        b0_v, b1_v, b2_v;
	ctx_t        b0_ctx, b1_ctx, b2_ctx;
	u32_t        ip_mag;

	// the pipeline moves unless a finished word is held at the output
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.behav_en  <= '0;
			cfg_q.max_force <= '0;
			cfg_q.max_speed <= '0;
			cfg_q.ip_dist   <= '0;
			cfg_q.fast_div  <= FAST_DIV_RESET;
			cfg_q.norm_div  <= NORM_DIV_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_ENABLE:    cfg_q.behav_en  <= cfg_wdata[2:0];
				CFG_MAX_FORCE: cfg_q.max_force <= cfg_wdata[30:0];
				CFG_MAX_SPEED: cfg_q.max_speed <= cfg_wdata[30:0];
				CFG_IP_DIST:   cfg_q.ip_dist   <= s32_t'(cfg_wdata);
				CFG_FAST_DIV:  cfg_q.fast_div  <= cfg_wdata[30:0];
				CFG_NORM_DIV:  cfg_q.norm_div  <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	assign ip_mag = mag(cfg_q.ip_dist);

	// input capture and target offset
	always_comb begin
		n_s0    = '0;
		n_s0.tx = target_x;
		n_s0.ty = target_y;
		n_s0.px = pos_x;
		n_s0.py = pos_y;
		n_s0.vx = vel_x;
		n_s0.vy = vel_y;
		n_s0.dx = ssub(target_x, pos_x);
		n_s0.dy = ssub(target_y, pos_y);
	end

	psf_len u_len_d (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vld (v_s0), .ctx (c_s0), .vec_x (c_s0.dx), .vec_y (c_s0.dy),
		.len_valid (l1_v), .len_ctx (l1_ctx), .len (l1_len)
	);

	always_comb begin
		n_s1       = l1_ctx;
		n_s1.len_d = l1_len;
	end

	// seek desired velocity, interpose offset and fast arrive speed in parallel
	psf_scale u_seek (
		.clk (clk), .arst_n (arst_n), .en (en), .vld (v_s1), .ctx (c_s1),
		.a_x ({1'b0, mag(c_s1.dx)}), .a_y ({1'b0, mag(c_s1.dy)}),
		.b_x ({1'b0, cfg_q.max_speed}), .b_y ({1'b0, cfg_q.max_speed}),
		.den_x (c_s1.len_d), .den_y (c_s1.len_d),
		.q_valid (sk_v), .q_ctx (sk_ctx), .q_x (sk_x), .q_y (sk_y)
	);

	psf_scale u_offset (
		.clk (clk), .arst_n (arst_n), .en (en), .vld (v_s1), .ctx (c_s1),
		.a_x ({1'b0, mag(c_s1.dx)}), .a_y ({1'b0, mag(c_s1.dy)}),
		.b_x (ip_mag), .b_y (ip_mag),
		.den_x (c_s1.len_d), .den_y (c_s1.len_d),
		.q_valid (), .q_ctx (), .q_x (of_x), .q_y (of_y)
	);

	psf_scale u_speed1 (
		.clk (clk), .arst_n (arst_n), .en (en), .vld (v_s1), .ctx (c_s1),
		.a_x ({1'b0, c_s1.len_d}), .a_y ('0),
		.b_x (FRAC_ONE), .b_y ('0),
		.den_x ({1'b0, cfg_q.fast_div}), .den_y ('0),
		.q_valid (), .q_ctx (), .q_x (sp1_q), .q_y (sp1_unused)
	);

	always_comb begin
		n_s2        = sk_ctx;
		n_s2.seek_x = ssub(fix_scale(sk_x, sk_ctx.dx[31], sk_ctx.len_d == '0), sk_ctx.vx);
		n_s2.seek_y = ssub(fix_scale(sk_y, sk_ctx.dy[31], sk_ctx.len_d == '0), sk_ctx.vy);
		n_s2.off_x  = fix_scale(of_x, sk_ctx.dx[31] ^ cfg_q.ip_dist[31], sk_ctx.len_d == '0);
		n_s2.off_y  = fix_scale(of_y, sk_ctx.dy[31] ^ cfg_q.ip_dist[31], sk_ctx.len_d == '0);
		if (cfg_q.fast_div == '0 || sp1_q > {33'd0, cfg_q.max_speed}) begin
			n_s2.spd1 = cfg_q.max_speed;
		end else begin
			n_s2.spd1 = sp1_q[30:0];
		end
	end

	// interpose point, then its offset from the agent
	always_comb begin
		n_s3       = c_s2;
		n_s3.to2_x = sadd(c_s2.tx, c_s2.off_x);
		n_s3.to2_y = sadd(c_s2.ty, c_s2.off_y);
		n_s4       = c_s3;
		n_s4.to2_x = ssub(c_s3.to2_x, c_s3.px);
		n_s4.to2_y = ssub(c_s3.to2_y, c_s3.py);
	end

	psf_len u_len_ip (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vld (v_s4), .ctx (c_s4), .vec_x (c_s4.to2_x), .vec_y (c_s4.to2_y),
		.len_valid (l2_v), .len_ctx (l2_ctx), .len (l2_len)
	);

	always_comb begin
		n_s5       = l2_ctx;
		n_s5.dist2 = l2_len;
	end

	// arrive velocity and normal arrive speed in parallel
	psf_scale u_arrive (
		.clk (clk), .arst_n (arst_n), .en (en), .vld (v_s5), .ctx (c_s5),
		.a_x ({1'b0, mag(c_s5.dx)}), .a_y ({1'b0, mag(c_s5.dy)}),
		.b_x ({1'b0, c_s5.spd1}), .b_y ({1'b0, c_s5.spd1}),
		.den_x (c_s5.len_d), .den_y (c_s5.len_d),
		.q_valid (a1_v), .q_ctx (a1_ctx), .q_x (a1_x), .q_y (a1_y)
	);

	psf_scale u_speed2 (
		.clk (clk), .arst_n (arst_n), .en (en), .vld (v_s5), .ctx (c_s5),
		.a_x ({1'b0, c_s5.dist2}), .a_y ('0),
		.b_x (FRAC_ONE), .b_y ('0),
		.den_x ({1'b0, cfg_q.norm_div}), .den_y ('0),
		.q_valid (), .q_ctx (), .q_x (sp2_q), .q_y (sp2_unused)
	);

	always_comb begin
		n_s6 = a1_ctx;
		if (a1_ctx.len_d == '0) begin
			n_s6.arr_x = '0;
			n_s6.arr_y = '0;
		end else begin
			n_s6.arr_x = ssub(fix_scale(a1_x, a1_ctx.dx[31], 1'b0), a1_ctx.vx);
			n_s6.arr_y = ssub(fix_scale(a1_y, a1_ctx.dy[31], 1'b0), a1_ctx.vy);
		end
		if (cfg_q.norm_div == '0 || sp2_q > {33'd0, cfg_q.max_speed}) begin
			n_s6.spd2 = cfg_q.max_speed;
		end else begin
			n_s6.spd2 = sp2_q[30:0];
		end
	end

	// interpose arrive velocity
	psf_scale u_ipose (
		.clk (clk), .arst_n (arst_n), .en (en), .vld (v_s6), .ctx (c_s6),
		.a_x ({1'b0, mag(c_s6.to2_x)}), .a_y ({1'b0, mag(c_s6.to2_y)}),
		.b_x ({1'b0, c_s6.spd2}), .b_y ({1'b0, c_s6.spd2}),
		.den_x (c_s6.dist2), .den_y (c_s6.dist2),
		.q_valid (a2_v), .q_ctx (a2_ctx), .q_x (a2_x), .q_y (a2_y)
	);

	// interpose force, budget chain starts empty
	always_comb begin
		n_s7 = a2_ctx;
		if (a2_ctx.dist2 == '0) begin
			n_s7.ip_x = '0;
			n_s7.ip_y = '0;
		end else begin
			n_s7.ip_x = ssub(fix_scale(a2_x, a2_ctx.to2_x[31], 1'b0), a2_ctx.vx);
			n_s7.ip_y = ssub(fix_scale(a2_y, a2_ctx.to2_y[31], 1'b0), a2_ctx.vy);
		end
		n_s7.run_x = '0;
		n_s7.run_y = '0;
		n_s7.tot_x = '0;
		n_s7.tot_y = '0;
		n_s7.lr    = '0;
		n_s7.go    = 1'b1;
		n_s7.act   = 1'b0;
	end

	// budget steps in priority order
	psf_budget u_step_seek (
		.clk (clk), .arst_n (arst_n), .en (en), .vld (v_s7), .ctx (c_s7),
		.force_x (c_s7.seek_x), .force_y (c_s7.seek_y),
		.act (cfg_q.behav_en[EN_SEEK]), .max_force (cfg_q.max_force),
		.step_valid (b0_v), .step_ctx (b0_ctx)
	);

	psf_budget u_step_arrive (
		.clk (clk), .arst_n (arst_n), .en (en), .vld (b0_v), .ctx (b0_ctx),
		.force_x (b0_ctx.arr_x), .force_y (b0_ctx.arr_y),
		.act (cfg_q.behav_en[EN_ARRIVE]), .max_force (cfg_q.max_force),
		.step_valid (b1_v), .step_ctx (b1_ctx)
	);

	psf_budget u_step_ipose (
		.clk (clk), .arst_n (arst_n), .en (en), .vld (b1_v), .ctx (b1_ctx),
		.force_x (b1_ctx.ip_x), .force_y (b1_ctx.ip_y),
		.act (cfg_q.behav_en[EN_IPOSE]), .max_force (cfg_q.max_force),
		.step_valid (b2_v), .step_ctx (b2_ctx)
	);

	// final truncation of the total to max_force
	psf_len u_len_tot (
		.clk (clk), .arst_n (arst_n), .en (en),
		.vld (b2_v), .ctx (b2_ctx), .vec_x (b2_ctx.tot_x), .vec_y (b2_ctx.tot_y),
		.len_valid (lf_v), .len_ctx (lf_ctx), .len (lf_len)
	);

	// act now marks a total that is too long
	always_comb begin
		n_s8     = lf_ctx;
		n_s8.lr  = lf_len;
		n_s8.act = lf_len > {1'b0, cfg_q.max_force};
	end

	psf_scale u_trunc (
		.clk (clk), .arst_n (arst_n), .en (en), .vld (v_s8), .ctx (c_s8),
		.a_x ({1'b0, mag(c_s8.tot_x)}), .a_y ({1'b0, mag(c_s8.tot_y)}),
		.b_x ({1'b0, cfg_q.max_force}), .b_y ({1'b0, cfg_q.max_force}),
		.den_x (c_s8.lr), .den_y (c_s8.lr),
		.q_valid (sf_v), .q_ctx (sf_ctx), .q_x (sf_x), .q_y (sf_y)
	);

	always_comb begin
		if (sf_ctx.act) begin
			fx_c = fix_scale(sf_x, sf_ctx.tot_x[31], sf_ctx.lr == '0);
			fy_c = fix_scale(sf_y, sf_ctx.tot_y[31], sf_ctx.lr == '0);
		end else begin
			fx_c = sf_ctx.tot_x;
			fy_c = sf_ctx.tot_y;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s0 <= in_valid;
			v_s1 <= l1_v;
			v_s2 <= sk_v;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= l2_v;
			v_s6 <= a1_v;
			v_s7 <= a2_v;
			v_s8 <= lf_v;
			v_s9 <= sf_v;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			c_s0  <= n_s0;
			c_s1  <= n_s1;
			c_s2  <= n_s2;
			c_s3  <= n_s3;
			c_s4  <= n_s4;
			c_s5  <= n_s5;
			c_s6  <= n_s6;
			c_s7  <= n_s7;
			c_s8  <= n_s8;
			fx_s9 <= fx_c;
			fy_s9 <= fy_c;
		end
	end

	assign out_valid = v_s9;
	assign force_x   = fx_s9;
	assign force_y   = fy_s9;

endmodule

`default_nettype wire

// File: verif/prioritized_steering_force_top_tb.sv
// testbench for the prioritised seek / arrive / interpose steering force pipeline
`default_nettype none

module prioritized_steering_force_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psf_pkg::*;

	localparam int LATENCY = 691;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	s32_t        target_x, target_y, pos_x, pos_y, vel_x, vel_y;
	logic        out_valid;
	logic        out_stall;
	s32_t        force_x, force_y;
	logic        cfg_wen;
	logic [2:0]  cfg_idx;
	logic [31:0] cfg_wdata;

	// predictor copy of the registers
	logic [2:0]   m_enable;
	longint       m_max_force, m_max_speed, m_ip_dist, m_fast_div, m_norm_div;

	s32_t   want_x[$];
	s32_t   want_y[$];
	int     errors;
	int     send_idle_pct;
	int     recv_stall_pct;
	bit     hold_off;

	prioritized_steering_force_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.target_x(target_x), .target_y(target_y),
		.pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.force_x(force_x), .force_y(force_y),
		.cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// fixed point helpers for the predictor
	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint abs64(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint root_floor(input logic [63:0] n);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint vec_len(input longint x, input longint y);
		logic [63:0] ax, ay;
		ax = abs64(x);
		ay = abs64(y);
		return root_floor(ax * ax + ay * ay);
	endfunction

	function automatic longint scale_part(input longint c, input longint m, input bit neg_m,
			input longint len);
		logic [63:0] q;
		bit neg;
		if (len == 0) return 0;
		q = (64'(abs64(c)) * 64'(m)) / 64'(len);
		neg = (c < 0) != neg_m;
		if (neg) return clamp32(-longint'(q));
		return clamp32(longint'(q));
	endfunction

	task automatic scale_vec(input longint x, input longint y, input longint m, input bit neg_m,
			output longint rx, output longint ry);
		longint len;
		len = vec_len(x, y);
		rx = scale_part(x, m, neg_m, len);
		ry = scale_part(y, m, neg_m, len);
	endtask

	task automatic arrive_at(input longint tx, input longint ty, input longint px, input longint py,
			input longint vx, input longint vy, input longint divisor,
			output longint fx, output longint fy);
		longint dx, dy, span, speed, sx, sy;
		dx = clamp32(tx - px);
		dy = clamp32(ty - py);
		span = vec_len(dx, dy);
		fx = 0;
		fy = 0;
		if (span != 0) begin
			if (divisor == 0) speed = m_max_speed;
			else speed = (span << FRAC_BITS) / divisor;
			if (speed > m_max_speed) speed = m_max_speed;
			scale_vec(dx, dy, speed, 1'b0, sx, sy);
			fx = clamp32(sx - vx);
			fy = clamp32(sy - vy);
		end
	endtask

	// add a running sum into the budgeted total; go drops when no budget is left
	task automatic spend_budget(inout longint totx, inout longint toty, input longint fx,
			input longint fy, output bit go);
		longint left, add, sx, sy;
		left = m_max_force - vec_len(totx, toty);
		go = left > 0;
		if (go) begin
			add = vec_len(fx, fy);
			if (add > left) add = left;
			scale_vec(fx, fy, add, 1'b0, sx, sy);
			totx = clamp32(totx + sx);
			toty = clamp32(toty + sy);
		end
	endtask

	task automatic predict_force(input s32_t tx, input s32_t ty, input s32_t px, input s32_t py,
			input s32_t vx, input s32_t vy);
		longint totx, toty, runx, runy, fx, fy, sx, sy, dx, dy, ox, oy;
		bit go;
		totx = 0; toty = 0; runx = 0; runy = 0;
		go = 1'b1;
		dx = clamp32(longint'(tx) - px);
		dy = clamp32(longint'(ty) - py);
		if (go && m_enable[EN_SEEK]) begin
			scale_vec(dx, dy, m_max_speed, 1'b0, sx, sy);
			runx = clamp32(runx + clamp32(sx - vx));
			runy = clamp32(runy + clamp32(sy - vy));
			spend_budget(totx, toty, runx, runy, go);
		end
		if (go && m_enable[EN_ARRIVE]) begin
			arrive_at(tx, ty, px, py, vx, vy, m_fast_div, fx, fy);
			runx = clamp32(runx + fx);
			runy = clamp32(runy + fy);
			spend_budget(totx, toty, runx, runy, go);
		end
		if (go && m_enable[EN_IPOSE]) begin
			scale_vec(dx, dy, abs64(m_ip_dist), m_ip_dist < 0, ox, oy);
			arrive_at(clamp32(longint'(tx) + ox), clamp32(longint'(ty) + oy), px, py, vx, vy,
				m_norm_div, fx, fy);
			runx = clamp32(runx + fx);
			runy = clamp32(runy + fy);
			spend_budget(totx, toty, runx, runy, go);
		end
		if (vec_len(totx, toty) > m_max_force) begin
			scale_vec(totx, toty, m_max_force, 1'b0, sx, sy);
			totx = sx;
			toty = sy;
		end
		want_x.push_back(s32_t'(totx));
		want_y.push_back(s32_t'(toty));
	endtask

	task automatic report_mismatch(input string what, input s32_t got, input s32_t exp);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (want_x.size() == 0) begin
				report_mismatch("unexpected word", force_x, 0);
			end else begin
				if (force_x !== want_x[0]) report_mismatch("force_x", force_x, want_x[0]);
				if (force_y !== want_y[0]) report_mismatch("force_y", force_y, want_y[0]);
				void'(want_x.pop_front());
				void'(want_y.pop_front());
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			CFG_ENABLE:    m_enable = val[2:0];
			CFG_MAX_FORCE: m_max_force = val[30:0];
			CFG_MAX_SPEED: m_max_speed = val[30:0];
			CFG_IP_DIST:   m_ip_dist = longint'(signed'(val));
			CFG_FAST_DIV:  m_fast_div = val[30:0];
			CFG_NORM_DIV:  m_norm_div = val[30:0];
			default: ;
		endcase
	endtask

	task automatic setup(input logic [31:0] en, input logic [31:0] mf, input logic [31:0] ms,
			input logic [31:0] ip, input logic [31:0] fd, input logic [31:0] nd);
		write_reg(CFG_ENABLE, en);
		write_reg(CFG_MAX_FORCE, mf);
		write_reg(CFG_MAX_SPEED, ms);
		write_reg(CFG_IP_DIST, ip);
		write_reg(CFG_FAST_DIV, fd);
		write_reg(CFG_NORM_DIV, nd);
	endtask

	// send one word, waiting for acceptance; valid stays up into the next word
	task automatic send_word(input s32_t tx, input s32_t ty, input s32_t px, input s32_t py,
			input s32_t vx, input s32_t vy);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		target_x <= tx; target_y <= ty;
		pos_x <= px; pos_y <= py;
		vel_x <= vx; vel_y <= vy;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_force(tx, ty, px, py, vx, vy);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (want_x.size() != 0 && guard < 400000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
	endtask

	// random coordinate: mostly moderate, sometimes full range or extreme
	function automatic s32_t rand_coord();
		case ($urandom_range(9))
			0: return s32_t'($urandom());
			1: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			2: return s32_t'($urandom_range(16)) - 8;
			default: return s32_t'($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
		endcase
	endfunction

	task automatic send_random(input int n);
		repeat (n) send_word(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), rand_coord());
	endtask

	function automatic logic [31:0] rand_reg31();
		case ($urandom_range(3))
			0: return 32'h7fff_ffff;
			1: return $urandom_range(32'h0001_0000);
			default: return $urandom_range(32'h0100_0000);
		endcase
	endfunction

	task automatic test_directed();
		setup(32'd7, 32'h0010_0000, 32'h0008_0000, 32'h0002_0000, 32'd19661, 32'd39322);
		send_word(0, 0, 0, 0, 0, 0);
		send_word(32'sh0001_0000, 0, 0, 0, 0, 0);
		send_word(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 0, 0);
		send_word(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh7fff_ffff, 32'sh8000_0000);
		send_word(5, 5, 5, 5, 32'sh8000_0000, 32'sh7fff_ffff);
		send_word(32'sh0010_0000, 32'sh0010_0000, 0, 0, 32'sh0000_1000, 32'sh0000_1000);
		drain();
		// every combination of behaviours, including none
		for (int e = 0; e < 8; e++) begin
			drain();
			write_reg(CFG_ENABLE, e);
			send_word(32'sh0003_0000, -32'sh0004_0000, 0, 0, 32'sh0000_8000, 0);
		end
		drain();
		// zero divisors, zero budget, negative interpose distance
		setup(32'd7, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'd0);
		send_word(32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0);
		send_word(32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 32'sh7fff_ffff);
		drain();
		write_reg(CFG_MAX_FORCE, 0);
		send_word(32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0);
		drain();
		write_reg(CFG_IP_DIST, 32'hfffe_0000);
		write_reg(CFG_MAX_FORCE, 32'h0000_0100);
		send_word(32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0);
		send_word(-32'sh0003_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 32'sh0002_0000, 0);
		drain();
	endtask

	task automatic test_random_settings(input int rounds, input int per_round);
		repeat (rounds) begin
			setup($urandom_range(7), rand_reg31(), rand_reg31(), $urandom(),
				$urandom_range(1, 32'h7fff_ffff) & ($urandom_range(1) ? 32'h7fff_ffff : 32'hffff),
				$urandom_range(1, 32'h0010_0000));
			send_random(per_round);
			drain();
		end
	endtask

	task automatic test_idling();
		send_idle_pct = 0;  recv_stall_pct = 0;  test_random_settings(3, 22);
		send_idle_pct = 53; recv_stall_pct = 0;  test_random_settings(3, 22);
		send_idle_pct = 0;  recv_stall_pct = 53; test_random_settings(3, 22);
		send_idle_pct = 32; recv_stall_pct = 32; test_random_settings(3, 22);
	endtask

	// receiver holds off long enough for the pipeline to fill and stall its input
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 20;
		setup(32'd7, 32'h0100_0000, 32'h0080_0000, 32'h0001_0000, 32'd19661, 32'd39322);
		hold_off = 1'b1;
		fork
			send_random(900);
			begin
				repeat (1500) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		drain();
	endtask

	task automatic test_extremes();
		send_idle_pct = 10;
		recv_stall_pct = 10;
		setup(32'd7, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_random(30);
		drain();
		setup(32'd7, 32'd1, 32'd0, 32'h8000_0000, 32'd1, 32'd1);
		send_random(30);
		drain();
	endtask

	initial begin
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		target_x = 0; target_y = 0; pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0;
		cfg_wen = 1'b0;
		cfg_idx = CFG_ENABLE;
		cfg_wdata = '0;
		out_stall = 1'b0;
		m_enable = 0; m_max_force = 0; m_max_speed = 0; m_ip_dist = 0;
		m_fast_div = 19661; m_norm_div = 39322;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset values: nothing enabled, force zero
		send_word(32'sh0001_0000, 0, 0, 0, 32'sh0001_0000, 0);
		drain();
		test_directed();
		test_extremes();
		test_idling();
		test_backpressure();
		drain();
		repeat (LATENCY + 20) @(posedge clk);
		if (want_x.size() == 0 && errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#40ms;
		$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
src/psf_pkg.sv
src/psf_len.sv
src/psf_scale.sv
src/psf_budget.sv
src/prioritized_steering_force_top.sv
verif/prioritized_steering_force_top_tb.sv
